@@ hw/rtl/hsv_to_rgb_percent_core_macros.svh @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent_core_macros.svh
// assertion macros shared by the hsv to rgb checker
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PERCENT_CORE_MACROS_SVH
`define HSV_TO_RGB_PERCENT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define HSV2RGB_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// types, constants and helper functions of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// percent scale and hue geometry
	localparam logic [6:0] PCT_FULL   = 7'd100;
	localparam logic [8:0] DEG_SECTOR = 9'd60;
	localparam logic [3:0] NUM_SECTOR = 4'd6;

	// reciprocal multipliers: x / 100 and x / 60 for the value ranges in use
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [14:0] DIV60_RECIP  = 15'd17477;
	localparam int          DIV60_SHIFT  = 20;

	// hue sector codes
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	typedef logic [8:0] hue_t;
	typedef logic [6:0] pct_t;
	typedef logic [5:0] frac_t;
	typedef logic [2:0] sector_t;
	typedef logic [7:0] chan_t;

	// after the front stages: sector, hue offset, value and minimum level
	typedef struct packed {
		sector_t sector;
		frac_t   frac;
		pct_t    val;
		pct_t    lo;
	} front_t;

	// after the ramp stages
	typedef struct packed {
		sector_t sector;
		pct_t    val;
		pct_t    lo;
		pct_t    ramp;
	} ramp_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// hue / 60 for hue 0..511, as eight independent threshold compares
	function automatic logic [3:0] hue_div(input hue_t hue);
		logic [3:0] q;
		q = 4'd0;
		for (int i = 1; i <= 8; i++) begin
			if ({1'b0, hue} >= 10'(i * 60))
				q = 4'(i);
		end
		return q;
	endfunction

	// percent clamp to 100
	function automatic pct_t pct_clamp(input pct_t p);
		return (p > PCT_FULL) ? PCT_FULL : p;
	endfunction

endpackage

@@ hw/rtl/hsv2rgb_ifs.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_ifs
// valid/ready channels carrying one hsv beat and one rgb beat
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
	logic             valid;
	logic             ready;
	hsv2rgb_pkg::hue_t hue;
	hsv2rgb_pkg::pct_t saturation;
	hsv2rgb_pkg::pct_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic               valid;
	logic               ready;
	hsv2rgb_pkg::chan_t red;
	hsv2rgb_pkg::chan_t green;
	hsv2rgb_pkg::chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ hw/rtl/hsv_to_rgb_percent_core.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent_core
// hsv (degrees, percent, percent) to 8-bit rgb converter
// ----------------------------------------------------------------------------
// Takes one color per clock while the output is not stalled and passes it
// through six register stages (clamp and sector, minimum level, ramp
// product, ramp divide, channel routing, 255/100 scaling), each
// holding about one small multiply. Divisions by 100 and 60 are reciprocal
// multiplies. Saturation and brightness above 100 clamp to 100; hue wraps
// modulo 360. Back-pressure on the rgb side ripples back stage by stage, so
// bubbles are squeezed out and the input keeps accepting until every stage
// holds a beat. No configuration, no state between colors.
// ----------------------------------------------------------------------------
module hsv_to_rgb_percent_core (
	input  logic                 clk,
	input  logic                 arst_n,
	hsv2rgb_hsv_if.sink          hsv,
	hsv2rgb_rgb_if.source        rgb
);

	logic                front_valid, front_ready;
	hsv2rgb_pkg::front_t front_data;
	logic                ramp_valid, ramp_ready;
	hsv2rgb_pkg::ramp_t  ramp_data;
	hsv2rgb_pkg::rgb_t   rgb_data;

	// sector and minimum level
	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hsv.valid),
		.in_ready   (hsv.ready),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.out_valid  (front_valid),
		.out_ready  (front_ready),
		.out_data   (front_data)
	);

	// ramp within the sector
	hsv2rgb_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (ramp_valid),
		.out_ready (ramp_ready),
		.out_data  (ramp_data)
	);

	// channel routing and output scaling
	hsv2rgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ramp_valid),
		.in_ready  (ramp_ready),
		.in_data   (ramp_data),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.out_data  (rgb_data)
	);

	assign rgb.red   = rgb_data.red;
	assign rgb.green = rgb_data.green;
	assign rgb.blue  = rgb_data.blue;

endmodule

@@ hw/rtl/hsv2rgb_front.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_front
// stages 1-2: clamp, hue sector and offset, minimum level (100-s)*v/100
// ----------------------------------------------------------------------------
module hsv2rgb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::hue_t   hue,
	input  hsv2rgb_pkg::pct_t   saturation,
	input  hsv2rgb_pkg::pct_t   brightness,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::front_t out_data
);

	logic                 v_s1, v_s2;
	logic                 en1, en2;
	hsv2rgb_pkg::sector_t sector_s1;
	hsv2rgb_pkg::frac_t   frac_s1;
	hsv2rgb_pkg::pct_t    val_s1;
	logic [13:0]          prod_s1;
	hsv2rgb_pkg::front_t  data_s2;

	hsv2rgb_pkg::pct_t    sat_c, val_c;
	logic [3:0]           quot_c;
	hsv2rgb_pkg::sector_t sector_c;
	hsv2rgb_pkg::frac_t   frac_c;
	logic [13:0]          prod_c;
	logic [26:0]          lo_w;

	// stall chain
	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// stage 1 arithmetic
	always_comb begin
		sat_c    = hsv2rgb_pkg::pct_clamp(saturation);
		val_c    = hsv2rgb_pkg::pct_clamp(brightness);
		quot_c   = hsv2rgb_pkg::hue_div(hue);
		sector_c = (quot_c >= hsv2rgb_pkg::NUM_SECTOR) ?
			3'(quot_c - hsv2rgb_pkg::NUM_SECTOR) : 3'(quot_c);
		frac_c   = 6'(hue - 9'({5'd0, quot_c} * hsv2rgb_pkg::DEG_SECTOR));
		prod_c   = 14'(hsv2rgb_pkg::PCT_FULL - sat_c) * 14'(val_c);
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= sector_c;
			frac_s1   <= frac_c;
			val_s1    <= val_c;
			prod_s1   <= prod_c;
		end
	end

	// stage 2: divide by 100 through the reciprocal
	assign lo_w = 27'(prod_s1) * 27'(hsv2rgb_pkg::DIV100_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			data_s2.sector <= sector_s1;
			data_s2.frac   <= frac_s1;
			data_s2.val    <= val_s1;
			data_s2.lo     <= 7'(lo_w >> hsv2rgb_pkg::DIV100_SHIFT);
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

@@ hw/rtl/hsv2rgb_ramp.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_ramp
// stages 3-4: ramp = (v-min)*(hue mod 60)/60
// ----------------------------------------------------------------------------
module hsv2rgb_ramp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::front_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::ramp_t  out_data
);

	logic                 v_s3, v_s4;
	logic                 en3, en4;
	hsv2rgb_pkg::sector_t sector_s3;
	hsv2rgb_pkg::pct_t    val_s3, lo_s3;
	logic [12:0]          prod_s3;
	hsv2rgb_pkg::ramp_t   data_s4;
	logic [27:0]          ramp_w;

	// stall chain
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	// stage 3: span times hue offset, at most 100*59
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sector_s3 <= in_data.sector;
			val_s3    <= in_data.val;
			lo_s3     <= in_data.lo;
			prod_s3   <= 13'(in_data.val - in_data.lo) * 13'(in_data.frac);
		end
	end

	// stage 4: divide by 60 through the reciprocal
	assign ramp_w = 28'(prod_s3) * 28'(hsv2rgb_pkg::DIV60_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			data_s4.sector <= sector_s3;
			data_s4.val    <= val_s3;
			data_s4.lo     <= lo_s3;
			data_s4.ramp   <= 7'(ramp_w >> hsv2rgb_pkg::DIV60_SHIFT);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

@@ hw/rtl/hsv2rgb_mix.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// stages 5-6: sector routing to channels, then scaling by 255/100
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::ramp_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsv2rgb_pkg::rgb_t  out_data
);

	logic              v_s5, v_s6;
	logic              en5, en6;
	logic [14:0]       rnum_s5, gnum_s5, bnum_s5;
	hsv2rgb_pkg::rgb_t data_s6;

	hsv2rgb_pkg::pct_t up_c, down_c, r_c, g_c, b_c;
	logic [27:0]       rq_w, gq_w, bq_w;

	// stall chain, stage 6 is the output register
	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign in_ready = en5;

	// rising and falling edges of the ramp, routed per sector
	always_comb begin
		up_c   = in_data.lo + in_data.ramp;
		down_c = in_data.val - in_data.ramp;
		case (in_data.sector)
			hsv2rgb_pkg::SEC_RY: begin
				r_c = in_data.val; g_c = up_c;        b_c = in_data.lo;
			end
			hsv2rgb_pkg::SEC_YG: begin
				r_c = down_c;      g_c = in_data.val; b_c = in_data.lo;
			end
			hsv2rgb_pkg::SEC_GC: begin
				r_c = in_data.lo;  g_c = in_data.val; b_c = up_c;
			end
			hsv2rgb_pkg::SEC_CB: begin
				r_c = in_data.lo;  g_c = down_c;      b_c = in_data.val;
			end
			hsv2rgb_pkg::SEC_BM: begin
				r_c = up_c;        g_c = in_data.lo;  b_c = in_data.val;
			end
			default: begin
				r_c = in_data.val; g_c = in_data.lo;  b_c = down_c;
			end
		endcase
	end

	// stage 5: level times 255 as shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rnum_s5 <= {r_c, 8'd0} - 15'(r_c);
			gnum_s5 <= {g_c, 8'd0} - 15'(g_c);
			bnum_s5 <= {b_c, 8'd0} - 15'(b_c);
		end
	end

	// stage 6: divide by 100 through the reciprocal
	assign rq_w = 28'(rnum_s5) * 28'(hsv2rgb_pkg::DIV100_RECIP);
	assign gq_w = 28'(gnum_s5) * 28'(hsv2rgb_pkg::DIV100_RECIP);
	assign bq_w = 28'(bnum_s5) * 28'(hsv2rgb_pkg::DIV100_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			data_s6.red   <= 8'(rq_w >> hsv2rgb_pkg::DIV100_SHIFT);
			data_s6.green <= 8'(gq_w >> hsv2rgb_pkg::DIV100_SHIFT);
			data_s6.blue  <= 8'(bq_w >> hsv2rgb_pkg::DIV100_SHIFT);
		end
	end

	assign out_valid = v_s6;
	assign out_data  = data_s6;

endmodule

@@ hw/rtl/hsv2rgb_checker.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the hsv to rgb converter, bound to the top level
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_percent_core_macros.svh"

module hsv2rgb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input hsv2rgb_pkg::chan_t red,
	input hsv2rgb_pkg::chan_t green,
	input hsv2rgb_pkg::chan_t blue
);

	// a stalled result beat stays and holds its channels
	`HSV2RGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "stalled rgb beat changed or dropped")

	// with the output register empty no stage can be blocked
	`HSV2RGB_ASSERT(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	// reset leaves the pipeline empty
	`HSV2RGB_ASSERT(a_empty_after_reset, $rose(arst_n), !out_valid, "result beat right after reset")

	// an empty output with no earlier beat taken cannot stall a beat that arrived
	`HSV2RGB_ASSERT_NEXT(a_accept_no_stall, !out_valid && !(in_valid && in_ready), !out_valid || $past(in_ready), "output appeared from a stalled pipeline")

endmodule

bind hsv_to_rgb_percent_core hsv2rgb_checker u_hsv2rgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv.valid),
	.in_ready  (hsv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue)
);
